// File: rtl/x64ibe_pkg.sv
// Shared types and constants for the x86-64 instruction byte encoder.
// Used by every module of the encoder pipeline and by its checker.
package x64ibe_pkg;

   localparam int MaxBytes = 19;
   localparam int CountWidth = 5;

   localparam logic [7:0] PREFIX_OSZ = 8'h66;
   localparam logic [3:0] REX_FIXED = 4'h4;
   localparam logic [31:0] DISP8_MAX = 32'h0000_00FF;
   localparam logic [2:0] SIB_NO_INDEX = 3'b100;

   localparam logic [2:0] MODE_NONE = 3'd0;
   localparam logic [2:0] MODE_REG_RM = 3'd1;
   localparam logic [2:0] MODE_RM_ONLY = 3'd2;
   localparam logic [2:0] MODE_EXT_RM = 3'd3;
   localparam logic [2:0] MODE_EMBED = 3'd4;

   localparam logic [2:0] RM_DIRECT = 3'd0;
   localparam logic [2:0] RM_INDIRECT = 3'd1;
   localparam logic [2:0] RM_BASE_DISP = 3'd2;
   localparam logic [2:0] RM_BASE_SYM = 3'd3;
   localparam logic [2:0] RM_RIP_SYM = 3'd4;

   localparam logic [2:0] IMM_NONE = 3'd0;
   localparam logic [2:0] IMM_ONE = 3'd1;
   localparam logic [2:0] IMM_TWO = 3'd2;
   localparam logic [2:0] IMM_FOUR = 3'd3;
   localparam logic [2:0] IMM_EIGHT = 3'd4;

   localparam logic [2:0] KIND_PREFIX = 3'd0;
   localparam logic [2:0] KIND_REX = 3'd1;
   localparam logic [2:0] KIND_OPCODE = 3'd2;
   localparam logic [2:0] KIND_MODRM = 3'd3;
   localparam logic [2:0] KIND_SIB = 3'd4;
   localparam logic [2:0] KIND_DISP = 3'd5;
   localparam logic [2:0] KIND_IMM = 3'd6;

   localparam logic [1:0] MOD_INDIRECT = 2'd0;
   localparam logic [1:0] MOD_DISP8 = 2'd1;
   localparam logic [1:0] MOD_DISP32 = 2'd2;
   localparam logic [1:0] MOD_DIRECT = 2'd3;
   localparam logic [2:0] RM_SIB = 3'd4;
   localparam logic [2:0] RM_RIP = 3'd5;

   typedef struct packed {
      logic [23:0] opcode_bytes;
      logic [1:0]  opcode_len;
      logic        rex_w;
      logic        size_prefix;
      logic [2:0]  modrm_mode;
      logic [3:0]  reg_number;
      logic [2:0]  rm_kind;
      logic [3:0]  rm_register;
      logic [31:0] disp_value;
      logic [2:0]  imm_size_code;
      logic [63:0] imm_value;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [2:0] byte_kind;
      logic       is_last;
      logic       encode_error;
   } rsp_type;

   typedef struct packed {
      logic        err;
      logic        osz;
      logic        rex_en;
      logic [7:0]  rex_byte;
      logic [23:0] op_bytes;
      logic [1:0]  olen;
      logic        modrm_en;
      logic [7:0]  modrm_byte;
      logic        has_sib;
      logic [7:0]  sib_code;
      logic [2:0]  dsize;
      logic [31:0] dval;
      logic [3:0]  ibytes;
      logic [63:0] imm;
   } dec_type;

   typedef struct packed {
      logic                           err;
      logic [CountWidth-1:0]          count;
      logic [MaxBytes-1:0][7:0]       bytes;
      logic [MaxBytes-1:0][2:0]       kinds;
   } lay_type;

endpackage

// File: rtl/x64ibe_decode.sv
// Decode stage: turns one instruction form into prefix, REX, opcode, ModRM,
// SIB, displacement and immediate fields. Depends on x64ibe_pkg.
module x64ibe_decode import x64ibe_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  req_type in_req,
   output logic    in_ready,
   output logic    out_valid,
   output dec_type out_dec,
   input  logic    out_ready
);

   logic    valid_ff, valid_in;
   dec_type dec_ff, dec_in;

   logic       modrm_en, has_sib, err;
   logic [3:0] reg_f, embed;
   logic [1:0] mode_f;
   logic [2:0] rm_f;
   logic [2:0] dsize;
   logic [31:0] dval;
   logic       rex_r, rex_b;
   logic [3:0] ibytes;

   assign in_ready = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_dec = dec_ff;

   always_comb begin
      modrm_en = in_req.modrm_mode inside {MODE_REG_RM, MODE_RM_ONLY, MODE_EXT_RM};
      err = (in_req.opcode_len == 2'd0) || (in_req.modrm_mode > MODE_EMBED) ||
            (in_req.imm_size_code > IMM_EIGHT) || (modrm_en && in_req.rm_kind > RM_RIP_SYM);
      reg_f = (in_req.modrm_mode inside {MODE_REG_RM, MODE_EXT_RM}) ? in_req.reg_number : 4'd0;
      embed = (in_req.modrm_mode == MODE_EMBED) ? in_req.reg_number : 4'd0;
      has_sib = 1'b0;
      mode_f = MOD_INDIRECT;
      rm_f = in_req.rm_register[2:0];
      dsize = 3'd0;
      dval = 32'd0;
      case (in_req.rm_kind)
         RM_DIRECT: begin
            mode_f = MOD_DIRECT;
         end
         RM_RIP_SYM: begin
            rm_f = RM_RIP;
            dsize = 3'd4;
         end
         RM_INDIRECT: begin
            if (in_req.rm_register[2:0] == RM_RIP) begin
               mode_f = MOD_DISP8;
               dsize = 3'd1;
            end
         end
         RM_BASE_DISP: begin
            dval = in_req.disp_value;
            if (in_req.disp_value <= DISP8_MAX) begin
               mode_f = MOD_DISP8;
               dsize = 3'd1;
            end else begin
               mode_f = MOD_DISP32;
               dsize = 3'd4;
            end
         end
         RM_BASE_SYM: begin
            mode_f = MOD_DISP32;
            dsize = 3'd4;
         end
         default: begin
            mode_f = MOD_INDIRECT;
         end
      endcase
      if ((in_req.rm_kind inside {RM_INDIRECT, RM_BASE_DISP, RM_BASE_SYM}) &&
          in_req.rm_register[2:0] == RM_SIB) begin
         has_sib = 1'b1;
         rm_f = RM_SIB;
      end
      if (!modrm_en) begin
         has_sib = 1'b0;
         dsize = 3'd0;
      end
      rex_r = modrm_en && reg_f[3];
      rex_b = (modrm_en && in_req.rm_kind != RM_RIP_SYM && in_req.rm_register[3]) || embed[3];
      case (in_req.imm_size_code)
         IMM_ONE:   ibytes = 4'd1;
         IMM_TWO:   ibytes = 4'd2;
         IMM_FOUR:  ibytes = 4'd4;
         IMM_EIGHT: ibytes = 4'd8;
         default:   ibytes = 4'd0;
      endcase

      dec_in.err = err;
      dec_in.osz = in_req.size_prefix;
      dec_in.rex_en = in_req.rex_w || rex_r || rex_b;
      dec_in.rex_byte = {REX_FIXED, in_req.rex_w, rex_r, 1'b0, rex_b};
      dec_in.op_bytes = {in_req.opcode_bytes[23:8],
                         in_req.opcode_bytes[7:0] | {5'd0, embed[2:0]}};
      dec_in.olen = in_req.opcode_len;
      dec_in.modrm_en = modrm_en;
      dec_in.modrm_byte = {mode_f, reg_f[2:0], rm_f};
      dec_in.has_sib = has_sib;
      dec_in.sib_code = {2'b00, SIB_NO_INDEX, in_req.rm_register[2:0]};
      dec_in.dsize = dsize;
      dec_in.dval = dval;
      dec_in.ibytes = ibytes;
      dec_in.imm = in_req.imm_value;
   end

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         dec_ff <= dec_in;
      end
   end

endmodule

// File: rtl/x64ibe_layout.sv
// Layout stage: places the decoded fields into an ordered byte list with
// kinds and a byte count. Depends on x64ibe_pkg.
module x64ibe_layout import x64ibe_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  dec_type in_dec,
   output logic    in_ready,
   output logic    out_valid,
   output lay_type out_lay,
   input  logic    out_ready
);

   logic    valid_ff, valid_in;
   lay_type lay_ff, lay_in;

   logic [CountWidth-1:0] p_rex, p_op, p_modrm, p_sib, p_disp, p_imm, p_end;
   logic [CountWidth-1:0] slot, d_op, d_disp, d_imm;

   assign in_ready = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_lay = lay_ff;

   always_comb begin
      p_rex = {4'd0, in_dec.osz};
      p_op = p_rex + {4'd0, in_dec.rex_en};
      p_modrm = p_op + {3'd0, in_dec.olen};
      p_sib = p_modrm + {4'd0, in_dec.modrm_en};
      p_disp = p_sib + {4'd0, in_dec.has_sib};
      p_imm = p_disp + {2'd0, in_dec.dsize};
      p_end = p_imm + {1'b0, in_dec.ibytes};
   end

   always_comb begin
      lay_in.err = in_dec.err;
      lay_in.count = in_dec.err ? CountWidth'(1) : p_end;
      slot = '0;
      d_op = '0;
      d_disp = '0;
      d_imm = '0;
      for (int j = 0; j < MaxBytes; j++) begin
         slot = CountWidth'(j);
         d_op = slot - p_op;
         d_disp = slot - p_disp;
         d_imm = slot - p_imm;
         lay_in.bytes[j] = 8'd0;
         lay_in.kinds[j] = KIND_PREFIX;
         if (in_dec.err) begin
            lay_in.bytes[j] = 8'd0;
         end else if (slot < p_rex) begin
            lay_in.bytes[j] = PREFIX_OSZ;
         end else if (slot < p_op) begin
            lay_in.bytes[j] = in_dec.rex_byte;
            lay_in.kinds[j] = KIND_REX;
         end else if (slot < p_modrm) begin
            lay_in.bytes[j] = in_dec.op_bytes[{d_op[1:0], 3'b000} +: 8];
            lay_in.kinds[j] = KIND_OPCODE;
         end else if (slot < p_sib) begin
            lay_in.bytes[j] = in_dec.modrm_byte;
            lay_in.kinds[j] = KIND_MODRM;
         end else if (slot < p_disp) begin
            lay_in.bytes[j] = in_dec.sib_code;
            lay_in.kinds[j] = KIND_SIB;
         end else if (slot < p_imm) begin
            lay_in.bytes[j] = in_dec.dval[{d_disp[1:0], 3'b000} +: 8];
            lay_in.kinds[j] = KIND_DISP;
         end else if (slot < p_end) begin
            lay_in.bytes[j] = in_dec.imm[{d_imm[2:0], 3'b000} +: 8];
            lay_in.kinds[j] = KIND_IMM;
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         lay_ff <= lay_in;
      end
   end

endmodule

// File: rtl/x64ibe_emit.sv
// Emit stage: shifts the byte list out one byte per cycle and marks the
// last byte. Depends on x64ibe_pkg.
module x64ibe_emit import x64ibe_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  lay_type in_lay,
   output logic    in_ready,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   logic                     valid_ff, valid_in;
   logic [CountWidth-1:0]    count_ff, count_in;
   logic                     err_ff, err_in;
   logic [MaxBytes-1:0][7:0] bytes_ff, bytes_in;
   logic [MaxBytes-1:0][2:0] kinds_ff, kinds_in;
   logic                     last;

   assign last = (count_ff == CountWidth'(1));
   assign in_ready = !valid_ff || last;

   assign rsp_strobe = valid_ff;
   assign rsp_data.out_byte = bytes_ff[0];
   assign rsp_data.byte_kind = kinds_ff[0];
   assign rsp_data.is_last = last;
   assign rsp_data.encode_error = err_ff;

   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      err_in = err_ff;
      bytes_in = bytes_ff;
      kinds_in = kinds_ff;
      if (in_ready && in_valid) begin
         valid_in = 1'b1;
         count_in = in_lay.count;
         err_in = in_lay.err;
         bytes_in = in_lay.bytes;
         kinds_in = in_lay.kinds;
      end else if (valid_ff) begin
         // advance to the next byte
         valid_in = !last;
         count_in = count_ff - CountWidth'(1);
         bytes_in = {8'd0, bytes_ff[MaxBytes-1:1]};
         kinds_in = {KIND_PREFIX, kinds_ff[MaxBytes-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      err_ff <= err_in;
      bytes_ff <= bytes_in;
      kinds_ff <= kinds_in;
   end

endmodule

// File: rtl/x64_instruction_byte_encoder_unit.sv
// Top level of the x86-64 instruction byte encoder.
// Depends on x64ibe_pkg, x64ibe_decode, x64ibe_layout and x64ibe_emit.
//
// Usage:
//   Request channel: drive req_data with one instruction form and raise start;
//   the transfer happens at a rising edge where start is high and busy is low.
//   Response channel: each machine code byte appears on rsp_data for exactly
//   one cycle with rsp_strobe high, in instruction order; is_last marks the
//   final byte. An unsupported form gives one byte with encode_error set.
//   The first byte of a form passes through the input, decode, layout and
//   emit registers in that order, and waits in the layout register while
//   the emitter is still busy with the previous form.
//   Throughput: one byte per cycle; a form has 1 to 19 bytes and holds the
//   emitter until its last byte is out.
//   The emitter takes the next form in the cycle of the current last byte,
//   so bytes of back-to-back forms follow without gaps; busy rises when the
//   input, decode and layout stages are all full and the emitter cannot take a form.
//   Reset clears every stage valid bit; busy is low after reset.
//   The receiver cannot stall: every strobed byte is taken.
module x64_instruction_byte_encoder_unit import x64ibe_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_data,
   output logic    busy,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   logic    in_valid_ff, in_valid_in;
   req_type req_ff;
   logic    accept;

   logic    dec_in_ready, dec_valid;
   dec_type dec;
   logic    lay_in_ready, lay_valid;
   lay_type lay;
   logic    emit_in_ready;

   assign busy = in_valid_ff && !dec_in_ready;
   assign accept = start && !busy;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (dec_in_ready) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
   end

   x64ibe_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .in_req    (req_ff),
      .in_ready  (dec_in_ready),
      .out_valid (dec_valid),
      .out_dec   (dec),
      .out_ready (lay_in_ready)
   );

   x64ibe_layout u_layout (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_dec    (dec),
      .in_ready  (lay_in_ready),
      .out_valid (lay_valid),
      .out_lay   (lay),
      .out_ready (emit_in_ready)
   );

   x64ibe_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (lay_valid),
      .in_lay     (lay),
      .in_ready   (emit_in_ready),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

// File: rtl/x64ibe_checker.sv
// Port-level checker for the instruction byte encoder, bound to its top level.
// Depends on x64ibe_pkg.
module x64ibe_checker import x64ibe_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_strobe && !busy)
      else $error("strobe or busy right after reset");

   a_error_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.encode_error |->
         rsp_data.is_last && rsp_data.out_byte == 8'd0 && rsp_data.byte_kind == KIND_PREFIX)
      else $error("error result is not a single zero byte");

   a_bytes_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.is_last |=> rsp_strobe && !rsp_data.encode_error)
      else $error("gap inside an instruction");

   a_kind_order: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.is_last |=> rsp_data.byte_kind >= $past(rsp_data.byte_kind))
      else $error("byte kinds out of order");

endmodule

bind x64_instruction_byte_encoder_unit x64ibe_checker u_checker (.*);
